// File: hdl/ad_pkg.sv
package ad_pkg;

  // Request kinds carried on the slave side tuser.
  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_t;

  // Result status carried on the master side tuser.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // What every cell of one chain does in a cycle.
  typedef enum logic [1:0] {
    CH_HOLD   = 2'd0,
    CH_PUSH   = 2'd1,
    CH_APPEND = 2'd2,
    CH_POP    = 2'd3
  } chain_op_t;

  // Control handed from the index logic to the two cell chains and the output stage.
  typedef struct packed {
    chain_op_t f_op;
    chain_op_t r_op;
    status_t   status;
    logic      now_empty;
    logic      pop_front;
    logic      pop_rear;
  } ad_ctl_t;

endpackage

// File: hdl/ad_cell.sv
module ad_cell #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int INDEX      = 0
) (
  input  logic                          clk,
  input  ad_pkg::chain_op_t             op,
  input  logic [$clog2(DEPTH+1)-1:0]    count,
  input  logic [DATA_WIDTH-1:0]         wr_data,
  input  logic [DATA_WIDTH-1:0]         left_data,
  input  logic [DATA_WIDTH-1:0]         right_data,
  output logic [DATA_WIDTH-1:0]         data
);
  import ad_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic at_tail;

  // The first free place of the chain sits where the element count points.
  assign at_tail = (count == CW'(INDEX));

  always_ff @(posedge clk) begin
    case (op)
      CH_PUSH: begin
        data <= left_data;
      end
      CH_APPEND: begin
        if (at_tail) begin
          data <= wr_data;
        end
      end
      CH_POP: begin
        data <= right_data;
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

// File: hdl/ad_ctrl.sv
module ad_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  ad_pkg::req_t                  req_type,
  output ad_pkg::ad_ctl_t               ctl,
  output logic [$clog2(DEPTH+1)-1:0]    count
);
  import ad_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [IW-1:0] front;
  logic [IW-1:0] rear;
  logic [IW-1:0] front_next;
  logic [IW-1:0] rear_next;
  logic [CW-1:0] count_next;
  logic          empty;
  ad_ctl_t       ctl_raw;

  assign empty = (count == '0);

  always_comb begin
    front_next        = front;
    rear_next         = rear;
    count_next        = count;
    ctl_raw.f_op      = CH_HOLD;
    ctl_raw.r_op      = CH_HOLD;
    ctl_raw.status    = ST_DONE;
    ctl_raw.pop_front = 1'b0;
    ctl_raw.pop_rear  = 1'b0;
    case (req_type)
      REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
        if (empty) begin
          // The first element always lands in slot zero.
          front_next   = '0;
          rear_next    = '0;
          count_next   = CW'(1);
          ctl_raw.f_op = CH_PUSH;
          ctl_raw.r_op = CH_PUSH;
        end else if (req_type == REQ_PUSH_FRONT) begin
          if (front == '0) begin
            ctl_raw.status = ST_FULL;
          end else begin
            front_next   = front - IW'(1);
            count_next   = count + CW'(1);
            ctl_raw.f_op = CH_PUSH;
            ctl_raw.r_op = CH_APPEND;
          end
        end else begin
          if (rear == IW'(DEPTH - 1)) begin
            ctl_raw.status = ST_FULL;
          end else begin
            rear_next    = rear + IW'(1);
            count_next   = count + CW'(1);
            ctl_raw.f_op = CH_APPEND;
            ctl_raw.r_op = CH_PUSH;
          end
        end
      end
      default: begin
        if (empty) begin
          ctl_raw.status = ST_EMPTY;
        end else if (count == CW'(1)) begin
          // The last element leaves: both indices go back to slot zero.
          front_next        = '0;
          rear_next         = '0;
          count_next        = '0;
          ctl_raw.f_op      = (req_type == REQ_POP_FRONT) ? CH_POP : CH_HOLD;
          ctl_raw.r_op      = (req_type == REQ_POP_REAR) ? CH_POP : CH_HOLD;
          ctl_raw.pop_front = (req_type == REQ_POP_FRONT);
          ctl_raw.pop_rear  = (req_type == REQ_POP_REAR);
        end else if (req_type == REQ_POP_FRONT) begin
          front_next        = front + IW'(1);
          count_next        = count - CW'(1);
          ctl_raw.f_op      = CH_POP;
          ctl_raw.pop_front = 1'b1;
        end else begin
          rear_next        = rear - IW'(1);
          count_next       = count - CW'(1);
          ctl_raw.r_op     = CH_POP;
          ctl_raw.pop_rear = 1'b1;
        end
      end
    endcase
    ctl_raw.now_empty = (count_next == '0);
  end

  // The chains only move on an accepted transaction.
  always_comb begin
    ctl = ctl_raw;
    if (!fire) begin
      ctl.f_op = CH_HOLD;
      ctl.r_op = CH_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      rear  <= '0;
      count <= '0;
    end else if (fire) begin
      front <= front_next;
      rear  <= rear_next;
      count <= count_next;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count beyond the depth");

  a_span_matches_count: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> ((CW'(rear) + CW'(1) - CW'(front)) == count))
    else $error("index span disagrees with the element count");

  a_empty_indices: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (front == '0 && rear == '0))
    else $error("indices not at slot zero while empty");

  a_refused_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (fire && ctl.status != ST_DONE) |=> ($stable(count) && $stable(front) && $stable(rear)))
    else $error("refused request changed the deque");
`endif

endmodule

// File: hdl/array_deque.sv
// array_deque: a double-ended queue over a linear, non-wrapping array of DEPTH slots of
// DATA_WIDTH bits. Each slave transaction carries one request in s_tuser (push front, push
// rear, pop front, pop rear) and, for pushes, the value in s_tdata; each request yields exactly
// one master transaction with a status in m_tuser (done, refused as full, refused as empty)
// and, in m_tdata, the popped value (zero unless a pop succeeded) and a flag that is set when
// the deque is empty afterwards. The array does not wrap: a front push is refused once the front
// has reached slot zero and a rear push once the rear has reached the last slot, even if slots
// are free at the other end. The first push into an empty deque goes to slot zero. Every request
// completes in the cycle it is accepted and its result is registered, so one transaction is
// taken per clock cycle while results are being taken; the two cell chains move by one
// place per request. The block keeps taking requests while a result waits, as long as the
// result register is emptied in the same cycle. There is no clearing pass: the block is ready
// straight after reset.
module array_deque #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  // s_tdata fields from bit 0: push_value (DATA_WIDTH bits, signed), zero padding.
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]             s_tdata,
  // s_tuser fields from bit 0: req_type (2 bits).
  input  logic [1:0]                                  s_tuser,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  // m_tdata fields from bit 0: popped_value (DATA_WIDTH bits, signed), now_empty (1 bit),
  // zero padding.
  output logic [((DATA_WIDTH+8)/8)*8-1:0]             m_tdata,
  // m_tuser fields from bit 0: status (2 bits).
  output logic [1:0]                                  m_tuser
);
  import ad_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = ((DATA_WIDTH + 8) / 8) * 8;

  logic                  fire;
  logic [DATA_WIDTH-1:0] push_value;
  req_t                  req_type;
  ad_ctl_t               ctl;
  logic [CW-1:0]         count;

  // Two copies of the contents. The front chain holds the elements counted from the front,
  // so its cell zero is always the front element; the rear chain holds them counted from the
  // rear. A push shifts one chain by a place and appends to the tail of the other; a pop
  // shifts only the chain of its own end. Both reads therefore come from a fixed cell.
  logic [DATA_WIDTH-1:0] f_data [DEPTH];
  logic [DATA_WIDTH-1:0] r_data [DEPTH];

  logic [DATA_WIDTH-1:0] popped;
  status_t               out_status;
  logic [DATA_WIDTH-1:0] out_value;
  logic                  out_empty;

  // The result register is the only buffer: a new request is taken whenever it is free or
  // being emptied in this cycle.
  assign s_tready   = !m_tvalid || m_tready;
  assign fire       = s_tvalid && s_tready;
  assign push_value = s_tdata[DATA_WIDTH-1:0];
  assign req_type   = req_t'(s_tuser);

  ad_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .req_type (req_type),
    .ctl      (ctl),
    .count    (count)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cells
    logic [DATA_WIDTH-1:0] f_left;
    logic [DATA_WIDTH-1:0] f_right;
    logic [DATA_WIDTH-1:0] r_left;
    logic [DATA_WIDTH-1:0] r_right;

    // Cell zero takes the pushed value on a shift; the last cell refills from itself on a
    // pop, which only ever leaves a place beyond the live elements.
    if (i == 0) begin : g_head
      assign f_left = push_value;
      assign r_left = push_value;
    end else begin : g_body
      assign f_left = f_data[i-1];
      assign r_left = r_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign f_right = f_data[i];
      assign r_right = r_data[i];
    end else begin : g_inner
      assign f_right = f_data[i+1];
      assign r_right = r_data[i+1];
    end

    ad_cell #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (i)
    ) u_f_cell (
      .clk        (clk),
      .op         (ctl.f_op),
      .count      (count),
      .wr_data    (push_value),
      .left_data  (f_left),
      .right_data (f_right),
      .data       (f_data[i])
    );

    ad_cell #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (i)
    ) u_r_cell (
      .clk        (clk),
      .op         (ctl.r_op),
      .count      (count),
      .wr_data    (push_value),
      .left_data  (r_left),
      .right_data (r_right),
      .data       (r_data[i])
    );
  end

  // A successful pop reads the head cell of the chain of its own end; everything else
  // returns zero.
  always_comb begin
    popped = '0;
    if (ctl.pop_front) begin
      popped = f_data[0];
    end else if (ctl.pop_rear) begin
      popped = r_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= ctl.status;
      out_value  <= popped;
      out_empty  <= ctl.now_empty;
    end
  end

  assign m_tdata = MW'({out_empty, out_value});
  assign m_tuser = out_status;

endmodule

// File: tb/array_deque_checker.sv
module array_deque_checker #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  // s_tdata fields from bit 0: push_value, zero padding.
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]     s_tdata,
  // s_tuser fields from bit 0: req_type.
  input  logic [1:0]                          s_tuser,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata fields from bit 0: popped_value, now_empty, zero padding.
  input  logic [((DATA_WIDTH+8)/8)*8-1:0]     m_tdata,
  // m_tuser fields from bit 0: status.
  input  logic [1:0]                          m_tuser,
  output int                                  errors,
  output int                                  pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import ad_pkg::*;

  localparam int IDX_W      = $clog2(DEPTH);
  localparam int MAX_REPORT = 100;

  typedef struct packed {
    status_t                 status;
    logic [DATA_WIDTH-1:0]   popped;
    logic                    now_empty;
  } deque_outcome_t;

  logic [DATA_WIDTH-1:0] slots [DEPTH];
  logic [IDX_W-1:0]      front_idx;
  logic [IDX_W-1:0]      rear_idx;
  logic                  dq_empty;
  deque_outcome_t        outcomes_due [$];

  function automatic void go_empty();
    front_idx = '0;
    rear_idx  = '0;
    dq_empty  = 1'b1;
  endfunction

  // Applies one request to the shadow deque and returns the outcome the block must give.
  function automatic deque_outcome_t apply_request(req_t kind, logic [DATA_WIDTH-1:0] value);
    deque_outcome_t r;
    r.status = ST_DONE;
    r.popped = '0;
    if (kind == REQ_PUSH_FRONT || kind == REQ_PUSH_REAR) begin
      if (dq_empty) begin
        front_idx = '0;
        rear_idx  = '0;
        slots[0]  = value;
        dq_empty  = 1'b0;
      end else if (kind == REQ_PUSH_FRONT) begin
        if (front_idx == '0) begin
          r.status = ST_FULL;
        end else begin
          front_idx        = front_idx - 1'b1;
          slots[front_idx] = value;
        end
      end else begin
        if (rear_idx == IDX_W'(DEPTH - 1)) begin
          r.status = ST_FULL;
        end else begin
          rear_idx        = rear_idx + 1'b1;
          slots[rear_idx] = value;
        end
      end
    end else if (dq_empty) begin
      r.status = ST_EMPTY;
    end else if (kind == REQ_POP_FRONT) begin
      r.popped = slots[front_idx];
      if (front_idx >= rear_idx) go_empty();
      else front_idx = front_idx + 1'b1;
    end else begin
      r.popped = slots[rear_idx];
      if (rear_idx <= front_idx) go_empty();
      else rear_idx = rear_idx - 1'b1;
    end
    r.now_empty = dq_empty;
    return r;
  endfunction

  task automatic check_field(string name, logic [DATA_WIDTH-1:0] want,
                             logic [DATA_WIDTH-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORT)
        $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // The result side is handled before the request side, so that a result arriving with
  // nothing outstanding cannot be matched against a request taken at the same edge.
  always @(posedge clk) begin
    deque_outcome_t want;
    if (rst) begin
      go_empty();
      outcomes_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (outcomes_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORT)
            $display("%0t ns: result expected none, got status %0d value %0h", $time,
                     m_tuser, m_tdata[DATA_WIDTH-1:0]);
        end else begin
          want = outcomes_due.pop_front();
          check_field("status", DATA_WIDTH'(want.status), DATA_WIDTH'(m_tuser));
          check_field("popped_value", want.popped, m_tdata[DATA_WIDTH-1:0]);
          check_field("now_empty", DATA_WIDTH'(want.now_empty), DATA_WIDTH'(m_tdata[DATA_WIDTH]));
        end
      end
      if (s_tvalid && s_tready)
        outcomes_due.push_back(apply_request(req_t'(s_tuser), s_tdata[DATA_WIDTH-1:0]));
    end
    pending = outcomes_due.size();
  end

endmodule

// File: tb/array_deque_test.sv
module array_deque_test;

  timeunit 1ns;
  timeprecision 1ps;

  import ad_pkg::*;

  localparam int DEPTH        = 16;
  localparam int DATA_WIDTH   = 32;
  localparam int S_W          = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int M_W          = ((DATA_WIDTH + 8) / 8) * 8;
  // Number of random requests, and the point after which neither side idles any more.
  localparam int RANDOM_REQS  = 800;
  localparam int CALM_FROM    = 700;
  // The long hold-off on the result side starts once this many results have been taken.
  localparam int HOLD_AFTER   = 150;
  localparam int HOLD_CYCLES  = 40;
  // The block answers each request with a registered result; this drain settles the rest.
  localparam int DRAIN_CYCLES = 4;

  logic           clk      = 1'b0;
  logic           rst      = 1'b1;
  logic           s_tvalid = 1'b0;
  logic [S_W-1:0] s_tdata  = '0;
  logic [1:0]     s_tuser  = REQ_PUSH_FRONT;
  logic           m_tready = 1'b0;
  logic           s_tready;
  logic           m_tvalid;
  logic [M_W-1:0] m_tdata;
  logic [1:0]     m_tuser;

  int errors;
  int pending;
  int results_taken = 0;
  // Set for the last stretch of the run, where both sides go flat out.
  bit calm = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  array_deque #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  array_deque_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) chk (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending)
  );

  // Offers one request and holds it until the block takes it. Afterwards the request side
  // may go quiet for a short burst; otherwise valid simply stays high for the next request,
  // so it is never dropped and raised again within the same step.
  task automatic offer_request(input req_t kind, input logic [DATA_WIDTH-1:0] value,
                               input bit may_idle);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= S_W'(value);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (may_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side. It stalls in short random bursts, and once in the run it holds off for a
  // long stretch while requests keep coming, so that the result register stays full and
  // the block has to refuse further transactions on its request side.
  initial begin : result_sink
    int  idle;
    bit  held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && !held && results_taken >= HOLD_AFTER) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        idle = $urandom_range(1, 3);
        m_tready <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      if (!rst && m_tvalid) results_taken++;
    end
  end

  initial begin : stimulus
    int                    sent;
    int                    burst;
    int                    mode;
    int                    pick;
    int                    cut_pf;
    int                    cut_pr;
    int                    cut_qf;
    req_t                  kind;
    logic [DATA_WIDTH-1:0] value;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Both pops on an empty deque are refused as empty with a zero value.
    offer_request(REQ_POP_FRONT, '1, 1'b1);
    offer_request(REQ_POP_REAR, '0, 1'b1);
    // A front push into an empty deque lands in slot zero; a second front push then finds
    // the front already at slot zero and is refused as full.
    offer_request(REQ_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1);
    offer_request(REQ_PUSH_FRONT, 32'h0000_0001, 1'b1);
    offer_request(REQ_PUSH_REAR, 32'h8000_0000, 1'b1);
    offer_request(REQ_PUSH_REAR, 32'hFFFF_FFFF, 1'b1);
    // Popping the front frees slot zero, so a front push is accepted again.
    offer_request(REQ_POP_FRONT, 32'h1234_5678, 1'b1);
    offer_request(REQ_PUSH_FRONT, 32'h0000_0000, 1'b1);
    // Drain from the rear; the last pop takes the only element and empties the deque.
    offer_request(REQ_POP_REAR, '0, 1'b1);
    offer_request(REQ_POP_REAR, '1, 1'b1);
    offer_request(REQ_POP_REAR, '0, 1'b1);
    // A rear push into the empty deque also starts at slot zero. Filling on to the last slot
    // and pushing once more gives the refusal at the rear end.
    for (int i = 0; i <= DEPTH; i++)
      offer_request(REQ_PUSH_REAR, i[0] ? 32'hAAAA_AAAA : (32'h5555_5555 ^ i), 1'b1);

    // Random part, in bursts with a changing mix of requests. Some bursts build up at the
    // rear while the front creeps forward, some favour front pushes after front pops, some
    // drain, and some are even, so that both full refusals and the empty state keep coming.
    sent = 0;
    while (sent < RANDOM_REQS) begin
      mode  = $urandom_range(0, 3);
      burst = $urandom_range(10, 40);
      case (mode)
        0: begin
          cut_pf = 10; cut_pr = 70; cut_qf = 85;
        end
        1: begin
          cut_pf = 30; cut_pr = 60; cut_qf = 90;
        end
        2: begin
          cut_pf = 10; cut_pr = 20; cut_qf = 60;
        end
        default: begin
          cut_pf = 25; cut_pr = 50; cut_qf = 75;
        end
      endcase
      repeat (burst) begin
        pick = $urandom_range(0, 99);
        if (pick < cut_pf) kind = REQ_PUSH_FRONT;
        else if (pick < cut_pr) kind = REQ_PUSH_REAR;
        else if (pick < cut_qf) kind = REQ_POP_FRONT;
        else kind = REQ_POP_REAR;
        // Mostly random values, with the extremes of the signed range mixed in.
        case ($urandom_range(0, 11))
          0:       value = 32'h8000_0000;
          1:       value = 32'h7FFF_FFFF;
          2:       value = '0;
          3:       value = '1;
          default: value = $urandom();
        endcase
        if (sent >= CALM_FROM) calm = 1'b1;
        offer_request(kind, value, !calm);
        sent++;
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("array_deque_test: PASS");
    end else begin
      $display("array_deque_test: FAIL");
    end
    $finish;
  end

  // Well beyond the slowest correct run.
  initial begin : watchdog
    #200_000;
    $display("array_deque_test: FAIL");
    $finish;
  end

endmodule

// File: files.f
hdl/ad_pkg.sv
hdl/ad_cell.sv
hdl/ad_ctrl.sv
hdl/array_deque.sv
tb/array_deque_checker.sv
tb/array_deque_test.sv
